[rtl/core/salc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  // defaults for the top-level parameters
  localparam int ALARM_SLOTS_DEF      = 7;
  localparam int TICKS_PER_SECOND_DEF = 100;

  localparam int TICK_W    = 7;
  localparam int LEVEL_W   = 16;
  localparam int ELAPSED_W = 14;
  localparam int PHASE_W   = 4;
  localparam int ACC_W     = 24;

  localparam logic [LEVEL_W-1:0]   FULL_SCALE   = 16'hffff;
  localparam logic [LEVEL_W-1:0]   START_BELOW  = 16'h00ff;
  localparam logic [LEVEL_W-1:0]   KEY_STEP     = 16'd1024;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 14'h3fff;
  localparam logic [ELAPSED_W-1:0] LIMIT_RESET  = 14'd10800;
  localparam logic [PHASE_W-1:0]   STEP_PHASE   = 4'd5;
  localparam logic [PHASE_W-1:0]   PHASE_LAST   = 4'd9;
  localparam logic [7:0]           FRAC_FULL    = 8'hff;
  localparam logic [7:0]           INDEX_LAST   = 8'hff;
  localparam logic [5:0]           SECOND_LATE  = 6'd1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SLOT  = 2'd1,
    FUNC_CURVE = 2'd2,
    FUNC_LEVEL = 2'd3
  } func_e;

  localparam logic [1:0] KEY_TAP  = 2'd1;
  localparam logic [1:0] KEY_LONG = 2'd2;

  typedef struct packed {
    logic [6:0] mask;
    logic [4:0] hr;
    logic [5:0] mn;
  } slot_t;

  typedef struct packed {
    logic load_item;
    logic do_tick;
    logic scan_en;
    logic do_start;
    logic do_step;
    logic mac_a;
    logic mac_b;
    logic drive_curve;
    logic do_keys;
    logic do_misc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic step_due;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/salc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface salc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  day_of_week;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [1:0]  key_down;
  logic [1:0]  key_up;
  logic [1:0]  key_arm;
  logic [7:0]  slot_index;
  logic [15:0] data_word;
  logic [6:0]  select_mask;

  modport source (
    output valid, func, day_of_week, hour, minute, second, key_down, key_up, key_arm,
           slot_index, data_word, select_mask,
    input  ready
  );
  modport sink (
    input  valid, func, day_of_week, hour, minute, second, key_down, key_up, key_arm,
           slot_index, data_word, select_mask,
    output ready
  );
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_level;
  logic        drive_update;
  logic [15:0] level;
  logic        alarm_running;
  logic        accepted;

  modport source (
    output valid, drive_level, drive_update, level, alarm_running, accepted,
    input  ready
  );
  modport sink (
    input  valid, drive_level, drive_update, level, alarm_running, accepted,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/sunrise_alarm_light_controller.sv]
// Sunrise alarm light controller. Items arrive on in_i (func 0 is the 10 ms
// tick carrying time of day and debounced key states; 1 writes an alarm slot,
// 2 writes a sunrise-curve word, 3 sets the level), and every item gives
// exactly one result on out_o: last driven value, a driven-this-item flag, the
// level, the alarm flag and the slot-write accept flag. One item is worked on
// at a time. A slot write, curve write or set-level item passes through the
// load, execute and finish states; its result is registered in the finish
// state. A tick also runs the slot scan, the start check and the key handling,
// plus the curve interpolation where the alarm ramp steps the level (every
// 50 ms while an alarm runs): the alarm slots are compared one per cycle by a
// single comparator, and the interpolation needs two reads of the curve
// memory's read port and two passes through one 8x16 multiplier. The
// result sits in an output register, so the next item is taken while a result
// still waits. cfg_we_i writes the alarm limit in seconds (reset 10800); write
// it only while the block is idle. Curve entries have no reset value: program
// every entry the ramp can reach before arming an alarm.
`timescale 1ns / 1ps
`default_nettype none

module sunrise_alarm_light_controller #(
  parameter int ALARM_SLOTS      = salc_pkg::ALARM_SLOTS_DEF,
  parameter int TICKS_PER_SECOND = salc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [salc_pkg::ELAPSED_W-1:0] cfg_data_i,
  salc_in_if.sink                             in_i,
  salc_out_if.source                          out_o
);

  salc_pkg::cmd_t    cmd;
  salc_pkg::status_t status;

  // sequencer: one state per step of an item
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // state, slot table, curve memory, multiplier and output register
  salc_dp #(
    .ALARM_SLOTS      (ALARM_SLOTS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (in_i.func),
    .day_of_week_i   (in_i.day_of_week),
    .hour_i          (in_i.hour),
    .minute_i        (in_i.minute),
    .second_i        (in_i.second),
    .key_down_i      (in_i.key_down),
    .key_up_i        (in_i.key_up),
    .key_arm_i       (in_i.key_arm),
    .slot_index_i    (in_i.slot_index),
    .data_word_i     (in_i.data_word),
    .select_mask_i   (in_i.select_mask),
    .drive_level_o   (out_o.drive_level),
    .drive_update_o  (out_o.drive_update),
    .level_o         (out_o.level),
    .alarm_running_o (out_o.alarm_running),
    .accepted_o      (out_o.accepted)
  );

endmodule

`default_nettype wire

[rtl/core/salc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire salc_pkg::status_t status_i,
  output salc_pkg::cmd_t         cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_START = 4'd3;
  localparam logic [3:0] ST_STEP  = 4'd4;
  localparam logic [3:0] ST_RDA   = 4'd5;
  localparam logic [3:0] ST_MACA  = 4'd6;
  localparam logic [3:0] ST_MACB  = 4'd7;
  localparam logic [3:0] ST_DRIVE = 4'd8;
  localparam logic [3:0] ST_KEYS  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_tick) begin
          cmd_o.do_tick = 1'b1;
          state_d       = ST_SCAN;
        end else begin
          cmd_o.do_misc = 1'b1;
          state_d       = ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_last) state_d = ST_START;
      end
      ST_START: begin
        cmd_o.do_start = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.step_due) begin
          cmd_o.do_step = 1'b1;
          state_d       = ST_RDA;
        end else begin
          state_d = ST_KEYS;
        end
      end
      ST_RDA:  state_d = ST_MACA;   // curve[i] read in flight
      ST_MACA: begin
        cmd_o.mac_a = 1'b1;
        state_d     = ST_MACB;
      end
      ST_MACB: begin
        cmd_o.mac_b = 1'b1;
        state_d     = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd_o.drive_curve = 1'b1;
        state_d           = ST_KEYS;
      end
      ST_KEYS: begin
        cmd_o.do_keys = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/salc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_dp #(
  parameter int ALARM_SLOTS      = salc_pkg::ALARM_SLOTS_DEF,
  parameter int TICKS_PER_SECOND = salc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [salc_pkg::ELAPSED_W-1:0] cfg_data_i,
  input  wire salc_pkg::cmd_t                 cmd_i,
  output salc_pkg::status_t                   status_o,
  input  wire logic [1:0]                     func_i,
  input  wire logic [2:0]                     day_of_week_i,
  input  wire logic [4:0]                     hour_i,
  input  wire logic [5:0]                     minute_i,
  input  wire logic [5:0]                     second_i,
  input  wire logic [1:0]                     key_down_i,
  input  wire logic [1:0]                     key_up_i,
  input  wire logic [1:0]                     key_arm_i,
  input  wire logic [7:0]                     slot_index_i,
  input  wire logic [15:0]                    data_word_i,
  input  wire logic [6:0]                     select_mask_i,
  output logic [15:0]                         drive_level_o,
  output logic                                drive_update_o,
  output logic [15:0]                         level_o,
  output logic                                alarm_running_o,
  output logic                                accepted_o
);

  localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int LW     = salc_pkg::LEVEL_W;
  localparam int EW     = salc_pkg::ELAPSED_W;
  localparam int TW     = salc_pkg::TICK_W;
  localparam int PW     = salc_pkg::PHASE_W;
  localparam int AW     = salc_pkg::ACC_W;

  // latched item
  logic [1:0]  func_q;
  logic [2:0]  dow_q;
  logic [4:0]  hr_q;
  logic [5:0]  mn_q;
  logic [5:0]  sec_q;
  logic [1:0]  kd_q, ku_q, ka_q;
  logic [7:0]  idx_q;
  logic [15:0] word_q;
  logic [6:0]  sel_q;

  // block state
  logic [EW-1:0]     limit_q;
  logic [TW-1:0]     tick_d, tick_q;
  logic [PW-1:0]     phase_d, phase_q;
  logic              mode_d, mode_q;
  logic [LW-1:0]     bright_d, bright_q;
  logic [EW-1:0]     elapsed_d, elapsed_q;
  logic [LW-1:0]     drive_d, drive_q;
  logic              upd_d, upd_q;
  logic              acc_d, acc_q;
  logic              sec_evt_d, sec_evt_q;
  logic              match_d, match_q;
  logic [SLOT_W-1:0] scan_d, scan_q;
  logic [AW-1:0]     mac_d, mac_q;

  salc_pkg::slot_t   slots_q [ALARM_SLOTS];
  logic              slot_we;

  logic [LW-1:0]     curve_mem [256];
  logic [LW-1:0]     curve_rd_q;
  logic [7:0]        curve_addr;
  logic              curve_we;

  // combinational helpers
  logic [TW-1:0]     tick_inc;
  logic [EW-1:0]     elapsed_inc;
  logic [7:0]        frac;
  logic [7:0]        mul_a;
  logic [LW-1:0]     mul_b;
  logic [AW-1:0]     product;
  salc_pkg::slot_t   cur_slot;
  logic [7:0]        mask_ext;

  assign frac       = bright_q[7:0];
  assign curve_addr = cmd_i.mac_a ? bright_q[15:8] + 8'd1 : bright_q[15:8];
  assign mul_a      = cmd_i.mac_b ? frac : salc_pkg::FRAC_FULL - frac;
  assign mul_b      = (cmd_i.mac_b && bright_q[15:8] == salc_pkg::INDEX_LAST) ?
                      salc_pkg::FULL_SCALE : curve_rd_q;
  assign product    = AW'(mul_a) * AW'(mul_b);
  assign tick_inc   = tick_q + TW'(1);
  assign elapsed_inc = (elapsed_q < salc_pkg::ELAPSED_MAX) ? elapsed_q + EW'(1) : elapsed_q;
  assign cur_slot   = slots_q[scan_q];
  assign mask_ext   = {1'b0, cur_slot.mask};

  assign slot_we  = cmd_i.do_misc && func_q == salc_pkg::FUNC_SLOT &&
                    idx_q < 8'(ALARM_SLOTS);
  assign curve_we = cmd_i.do_misc && func_q == salc_pkg::FUNC_CURVE;

  always_comb begin
    tick_d    = tick_q;
    phase_d   = phase_q;
    mode_d    = mode_q;
    bright_d  = bright_q;
    elapsed_d = elapsed_q;
    drive_d   = drive_q;
    upd_d     = upd_q;
    acc_d     = acc_q;
    sec_evt_d = sec_evt_q;
    match_d   = match_q;
    scan_d    = scan_q;
    mac_d     = mac_q;

    if (cmd_i.load_item) begin
      upd_d = 1'b0;
      acc_d = 1'b1;
    end

    if (cmd_i.do_tick) begin
      sec_evt_d = (tick_inc == TW'(TICKS_PER_SECOND));
      match_d   = 1'b0;
      scan_d    = '0;
      if (sec_evt_d) begin
        tick_d  = '0;
        phase_d = '0;
      end else begin
        tick_d  = tick_inc;
        phase_d = (phase_q == salc_pkg::PHASE_LAST) ? '0 : phase_q + PW'(1);
      end
      if (sec_evt_d && mode_q) begin
        elapsed_d = elapsed_inc;
        if (limit_q <= elapsed_inc) begin
          mode_d   = 1'b0;
          bright_d = '0;
          drive_d  = '0;
          upd_d    = 1'b1;
        end
      end
    end

    if (cmd_i.scan_en) begin
      if (mask_ext[dow_q] && cur_slot.hr == hr_q && cur_slot.mn == mn_q) match_d = 1'b1;
      scan_d = scan_q + SLOT_W'(1);
    end

    if (cmd_i.do_start) begin
      if (sec_evt_q && !mode_q && bright_q < salc_pkg::START_BELOW && match_q &&
          sec_q <= salc_pkg::SECOND_LATE && ka_q == salc_pkg::KEY_LONG) begin
        mode_d    = 1'b1;
        elapsed_d = '0;
      end
    end

    if (cmd_i.do_step && bright_q < salc_pkg::FULL_SCALE) bright_d = bright_q + LW'(1);

    if (cmd_i.mac_a) mac_d = product;
    if (cmd_i.mac_b) mac_d = mac_q + product;

    if (cmd_i.drive_curve) begin
      drive_d = mac_q[AW-1:8];
      upd_d   = 1'b1;
    end

    if (cmd_i.do_keys && phase_q == '0) begin
      if (kd_q == salc_pkg::KEY_TAP) begin
        mode_d   = 1'b0;
        bright_d = '0;
        drive_d  = '0;
        upd_d    = 1'b1;
      end else if (kd_q == salc_pkg::KEY_LONG) begin
        mode_d   = 1'b0;
        bright_d = (bright_q >= salc_pkg::KEY_STEP) ? bright_q - salc_pkg::KEY_STEP : '0;
        drive_d  = bright_d;
        upd_d    = 1'b1;
      end else if (ku_q == salc_pkg::KEY_TAP) begin
        mode_d   = 1'b0;
        bright_d = salc_pkg::FULL_SCALE;
        drive_d  = bright_d;
        upd_d    = 1'b1;
      end else if (ku_q == salc_pkg::KEY_LONG) begin
        mode_d   = 1'b0;
        bright_d = (bright_q < salc_pkg::FULL_SCALE - salc_pkg::KEY_STEP) ?
                   bright_q + salc_pkg::KEY_STEP : salc_pkg::FULL_SCALE;
        drive_d  = bright_d;
        upd_d    = 1'b1;
      end
    end

    if (cmd_i.do_misc) begin
      case (func_q)
        salc_pkg::FUNC_SLOT: begin
          if (!slot_we) acc_d = 1'b0;
        end
        salc_pkg::FUNC_LEVEL: begin
          mode_d   = 1'b0;
          bright_d = word_q;
          drive_d  = word_q;
          upd_d    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= salc_pkg::LIMIT_RESET;
      tick_q    <= '0;
      phase_q   <= '0;
      mode_q    <= 1'b0;
      bright_q  <= '0;
      elapsed_q <= '0;
      drive_q   <= '0;
      upd_q     <= 1'b0;
      acc_q     <= 1'b1;
      sec_evt_q <= 1'b0;
      match_q   <= 1'b0;
      scan_q    <= '0;
      for (int k = 0; k < ALARM_SLOTS; k++) slots_q[k] <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      tick_q    <= tick_d;
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      bright_q  <= bright_d;
      elapsed_q <= elapsed_d;
      drive_q   <= drive_d;
      upd_q     <= upd_d;
      acc_q     <= acc_d;
      sec_evt_q <= sec_evt_d;
      match_q   <= match_d;
      scan_q    <= scan_d;
      if (slot_we) slots_q[idx_q[SLOT_W-1:0]] <= '{mask: sel_q, hr: hr_q, mn: mn_q};
    end
  end

  // item latch, accumulator and output register: payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      dow_q  <= day_of_week_i;
      hr_q   <= hour_i;
      mn_q   <= minute_i;
      sec_q  <= second_i;
      kd_q   <= key_down_i;
      ku_q   <= key_up_i;
      ka_q   <= key_arm_i;
      idx_q  <= slot_index_i;
      word_q <= data_word_i;
      sel_q  <= select_mask_i;
    end
    mac_q <= mac_d;
    if (cmd_i.out_load) begin
      drive_level_o   <= drive_q;
      drive_update_o  <= upd_q;
      level_o         <= bright_q;
      alarm_running_o <= mode_q;
      accepted_o      <= acc_q;
    end
  end

  // sunrise curve store
  always_ff @(posedge clk_i) begin
    if (curve_we) curve_mem[idx_q] <= word_q;
    curve_rd_q <= curve_mem[curve_addr];
  end

  assign status_o.is_tick   = (func_q == salc_pkg::FUNC_TICK);
  assign status_o.scan_last = (scan_q == SLOT_W'(ALARM_SLOTS - 1));
  assign status_o.step_due  = mode_q && (phase_q == '0 || phase_q == salc_pkg::STEP_PHASE);

endmodule

`default_nettype wire

[rtl/core/salc_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_level_i,
  input wire logic        out_update_i,
  input wire logic        out_accepted_i
);

  // a stalled result keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i))
    else $error("result level changed while stalled");

  // one item at a time: no transfer in straight after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is at work");

  // a rejected slot write never drives the light
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |-> !out_update_i)
    else $error("rejected slot write drove the light");

endmodule

bind sunrise_alarm_light_controller salc_chk u_salc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_level_i    (out_o.level),
  .out_update_i   (out_o.drive_update),
  .out_accepted_i (out_o.accepted)
);

`default_nettype wire

[dv/sunrise_alarm_light_controller_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the sunrise alarm light controller.
// The driver pulls items from a queue filled by the stimulus block, the monitor
// compares each result transfer with the oldest prediction. The light model
// below tracks the block's state from the items and the alarm limit writes
// that it actually sees on the wires.
module sunrise_alarm_light_controller_tb;
  import salc_pkg::*;

  localparam int NUM_SLOTS     = ALARM_SLOTS_DEF;
  localparam int TICKS_PER_SEC = TICKS_PER_SECOND_DEF;
  localparam int RAMP_EVERY    = 5;     // alarm ramp step every 50 ms
  localparam int SCAN_EVERY    = 10;    // keys looked at every 100 ms
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;    // longer than a stepping tick takes
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [1:0] KEY_IDLE = 2'd0;
  localparam logic [1:0] KEY_ODD  = 2'd3;   // unused code, must read as idle

  // idling mix per phase, cycled through in this order
  localparam int unsigned SEND_GAP_PCT [4] = '{0, 48, 0, 20};
  localparam int unsigned RECV_GAP_PCT [4] = '{0, 0, 48, 20};

  typedef struct packed {
    func_e       func;
    logic [2:0]  day_of_week;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  key_down;
    logic [1:0]  key_up;
    logic [1:0]  key_arm;
    logic [7:0]  slot_index;
    logic [15:0] data_word;
    logic [6:0]  select_mask;
  } light_item_t;

  typedef struct packed {
    logic [15:0] drive_level;
    logic        drive_update;
    logic [15:0] level;
    logic        alarm_running;
    logic        accepted;
  } light_result_t;

  typedef struct packed {
    logic [6:0] mask;
    logic [4:0] hr;
    logic [5:0] mn;
  } alarm_slot_t;

  // everything the bench drives starts at a known value
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [ELAPSED_W-1:0] cfg_data   = '0;
  logic                 send_valid = 1'b0;
  light_item_t          wire_item  = '0;
  logic                 take_ready = 1'b0;

  salc_in_if  light_in ();
  salc_out_if light_out ();

  assign light_in.valid       = send_valid;
  assign light_in.func        = wire_item.func;
  assign light_in.day_of_week = wire_item.day_of_week;
  assign light_in.hour        = wire_item.hour;
  assign light_in.minute      = wire_item.minute;
  assign light_in.second      = wire_item.second;
  assign light_in.key_down    = wire_item.key_down;
  assign light_in.key_up      = wire_item.key_up;
  assign light_in.key_arm     = wire_item.key_arm;
  assign light_in.slot_index  = wire_item.slot_index;
  assign light_in.data_word   = wire_item.data_word;
  assign light_in.select_mask = wire_item.select_mask;
  assign light_out.ready      = take_ready;

  sunrise_alarm_light_controller DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (light_in),
    .out_o      (light_out)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Light model state, owned by the driver process
  // ---------------------------------------------------------------------------
  logic [6:0]           tick_cnt;
  logic                 alarm_on;
  logic [15:0]          bright;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] limit_s;
  logic [15:0]          last_drive;
  alarm_slot_t          slots [NUM_SLOTS];
  logic [15:0]          curve_words [256];

  light_item_t   items_to_send [$];
  light_result_t light_results_due [$];

  int          items_queued    = 0;
  int          ticks_queued    = 0;
  int          results_checked = 0;
  int          fail_count      = 0;
  int          alarm_starts    = 0;
  int          alarm_timeouts  = 0;
  int          ramp_drives     = 0;
  int          key_actions     = 0;
  int          cycle_count     = 0;
  int          phase_no        = 0;
  int          hold_left       = 0;
  logic        hold_done       = 1'b0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;

  task automatic reset_light_model();
    tick_cnt   = '0;
    alarm_on   = 1'b0;
    bright     = '0;
    elapsed    = '0;
    limit_s    = LIMIT_RESET;
    last_drive = '0;
    for (int k = 0; k < NUM_SLOTS; k++) slots[k] = '0;
    for (int k = 0; k < 256; k++) curve_words[k] = '0;
  endtask

  // Sunrise curve lookup: upper byte picks the segment, lower byte blends
  // towards the next entry (full scale past the last one).
  function automatic logic [15:0] ramp_value(logic [15:0] lvl);
    int unsigned seg, frac, lo, hi;
    seg  = lvl[15:8];
    frac = lvl[7:0];
    lo   = curve_words[seg];
    hi   = (seg == 255) ? 32'hffff : curve_words[seg+1];
    return 16'((((255 - frac) * lo) + (frac * hi)) >> 8);
  endfunction

  task automatic step_light(input light_item_t it, output light_result_t res);
    logic       upd, acc, hit, keyed;
    logic [7:0] wide_mask;
    upd = 1'b0;
    acc = 1'b1;
    case (it.func)
      FUNC_TICK: begin
        tick_cnt = tick_cnt + 7'd1;
        if (tick_cnt == TICKS_PER_SEC) begin
          // once a second: time out a running alarm, then maybe start one
          tick_cnt = '0;
          if (alarm_on) begin
            if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
            if (limit_s <= elapsed) begin
              alarm_on   = 1'b0;
              bright     = '0;
              last_drive = '0;
              upd        = 1'b1;
              alarm_timeouts++;
            end
          end
          hit = 1'b0;
          if (it.second <= SECOND_LATE) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
              wide_mask = {1'b0, slots[k].mask};   // weekday seven never matches
              if (wide_mask[it.day_of_week] && slots[k].hr == it.hour &&
                  slots[k].mn == it.minute) hit = 1'b1;
            end
          end
          if (!alarm_on && bright < START_BELOW && hit && it.key_arm == KEY_LONG) begin
            alarm_on = 1'b1;
            elapsed  = '0;
            alarm_starts++;
          end
        end
        if (alarm_on && (tick_cnt % RAMP_EVERY) == 0) begin
          if (bright != FULL_SCALE) bright = bright + 16'd1;
          last_drive = ramp_value(bright);
          upd        = 1'b1;
          ramp_drives++;
        end
        if ((tick_cnt % SCAN_EVERY) == 0) begin
          // down before up, click before hold; code three counts as idle
          keyed = 1'b1;
          if (it.key_down == KEY_TAP) bright = '0;
          else if (it.key_down == KEY_LONG) begin
            bright = (bright >= KEY_STEP) ? bright - KEY_STEP : '0;
          end else if (it.key_up == KEY_TAP) bright = FULL_SCALE;
          else if (it.key_up == KEY_LONG) begin
            bright = (bright < FULL_SCALE - KEY_STEP) ? bright + KEY_STEP : FULL_SCALE;
          end else keyed = 1'b0;
          if (keyed) begin
            alarm_on   = 1'b0;
            last_drive = bright;
            upd        = 1'b1;
            key_actions++;
          end
        end
      end
      FUNC_SLOT: begin
        if (it.slot_index >= NUM_SLOTS) acc = 1'b0;
        else begin
          slots[it.slot_index].mask = it.select_mask;
          slots[it.slot_index].hr   = it.hour;
          slots[it.slot_index].mn   = it.minute;
        end
      end
      FUNC_CURVE: curve_words[it.slot_index] = it.data_word;
      default: begin
        alarm_on   = 1'b0;
        bright     = it.data_word;
        last_drive = bright;
        upd        = 1'b1;
      end
    endcase
    res.drive_level   = last_drive;
    res.drive_update  = upd;
    res.level         = bright;
    res.alarm_running = alarm_on;
    res.accepted      = acc;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a transfer happens at an edge with valid and ready both high; the
  // model is stepped with what was on the wires at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : feed
    light_result_t due;
    if (!rst_ni) begin
      send_valid <= 1'b0;
      wire_item  <= '0;
      reset_light_model();
    end else begin
      if (cfg_we) limit_s = cfg_data;
      if (send_valid && light_in.ready) begin
        step_light(wire_item, due);
        light_results_due.push_back(due);
      end
      if (!send_valid || light_in.ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          send_valid <= 1'b1;
          wire_item  <= items_to_send.pop_front();
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, early in the second phase while items are
  // still being offered, so the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase_no == 2 && send_valid) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    light_result_t want;
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else begin
      if (light_out.valid && take_ready) begin
        if (light_results_due.size() == 0) begin
          $error("result transfer with nothing expected, level %0h", light_out.level);
          fail_count++;
        end else begin
          want = light_results_due.pop_front();
          check_field("drive_level", want.drive_level, light_out.drive_level);
          check_field("drive_update", 16'(want.drive_update), 16'(light_out.drive_update));
          check_field("level", want.level, light_out.level);
          check_field("alarm_running", 16'(want.alarm_running), 16'(light_out.alarm_running));
          check_field("accepted", 16'(want.accepted), 16'(light_out.accepted));
          results_checked++;
        end
      end
      take_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sunrise_alarm_light_controller verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(light_item_t it);
    items_to_send.push_back(it);
    items_queued++;
    if (it.func == FUNC_TICK) ticks_queued++;
  endtask

  // level words around the key step and alarm start thresholds
  function automatic logic [15:0] pick_level();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h00fe;
      3:       return 16'h00ff;
      4:       return 16'h03ff;
      5:       return 16'h0400;
      6:       return 16'hfbfe;
      7:       return 16'hfbff;
      8:       return 16'hfc00;
      9:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // every field at full width; callers pin the fields that matter
  function automatic light_item_t noise_item();
    light_item_t it;
    it.func        = func_e'(2'($urandom_range(3)));
    it.day_of_week = 3'($urandom);
    it.hour        = 5'($urandom);
    it.minute      = 6'($urandom);
    it.second      = 6'($urandom);
    it.key_down    = 2'($urandom);
    it.key_up      = 2'($urandom);
    it.key_arm     = 2'($urandom);
    it.slot_index  = 8'($urandom);
    it.data_word   = 16'($urandom);
    it.select_mask = 7'($urandom);
    if (it.func == FUNC_LEVEL && $urandom_range(1) == 0) it.data_word = pick_level();
    return it;
  endfunction

  // Arm a slot, usually pull the level low, then tick at the slot's time with
  // the arm key held until a little past the next whole second.
  task automatic add_alarm_run();
    light_item_t it;
    int unsigned slot_no, day, hr, mn, ticks;
    slot_no = $urandom_range(NUM_SLOTS - 1);
    day     = $urandom_range(6);
    hr      = $urandom_range(23);
    mn      = $urandom_range(59);
    it = noise_item();
    it.func        = FUNC_SLOT;
    it.slot_index  = 8'(slot_no);
    it.select_mask = 7'($urandom) | 7'(1 << day);
    it.hour        = 5'(hr);
    it.minute      = 6'(mn);
    queue_item(it);
    if ($urandom_range(99) < 70) begin
      it = noise_item();
      it.func      = FUNC_LEVEL;
      it.data_word = ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom_range(16'h100));
      queue_item(it);
    end
    ticks = (TICKS_PER_SEC - (ticks_queued % TICKS_PER_SEC)) + $urandom_range(60);
    repeat (ticks) begin
      it = noise_item();
      it.func   = FUNC_TICK;
      it.hour   = 5'(hr);
      it.minute = 6'(mn);
      it.second = ($urandom_range(6) != 0) ? 6'($urandom_range(1)) : 6'($urandom_range(59, 2));
      if ($urandom_range(19) != 0) it.day_of_week = 3'(day);
      if ($urandom_range(19) != 0) it.key_arm = KEY_LONG;
      if ($urandom_range(99) >= 3) it.key_down = KEY_IDLE;
      if ($urandom_range(99) >= 3) it.key_up = KEY_IDLE;
      queue_item(it);
    end
  endtask

  // plain ticks with busy keys
  task automatic add_key_run();
    light_item_t it;
    repeat ($urandom_range(40, 10)) begin
      it = noise_item();
      it.func = FUNC_TICK;
      if ($urandom_range(99) >= 30) it.key_down = KEY_IDLE;
      if ($urandom_range(99) >= 30) it.key_up = KEY_IDLE;
      queue_item(it);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (items_to_send.size() != 0 || send_valid || light_results_due.size() != 0);
  endtask

  initial begin
    light_item_t          it;
    logic [ELAPSED_W-1:0] secs;
    int                   target, roll, mix;
    logic [ELAPSED_W-1:0] limit_plan [PHASES];
    limit_plan = '{14'd1, 14'd16383, 14'd0, 14'd3, 14'd10800, 14'd2, 14'd0, 14'd1};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The curve has no reset value: fill all of it before any ramp can read it.
    for (int k = 0; k < 256; k++) begin
      it = noise_item();
      it.func       = FUNC_CURVE;
      it.slot_index = 8'(k);
      queue_item(it);
    end

    // Directed: slot writes at the table edges and out of range, curve and
    // level extremes, then ten ticks ending on a key scan with an up hold.
    it = noise_item();
    it.func = FUNC_SLOT; it.slot_index = 8'd0; it.select_mask = 7'h7f;
    it.hour = 5'd23; it.minute = 6'd59;
    queue_item(it);
    it.slot_index = 8'(NUM_SLOTS - 1); it.select_mask = '0; it.hour = '0; it.minute = '0;
    queue_item(it);
    it.slot_index = 8'(NUM_SLOTS);
    queue_item(it);
    it.slot_index = 8'hff; it.select_mask = 7'h7f; it.hour = 5'h1f; it.minute = 6'h3f;
    queue_item(it);
    it = noise_item();
    it.func = FUNC_CURVE; it.slot_index = 8'hff; it.data_word = 16'h0000;
    queue_item(it);
    it.slot_index = 8'h00; it.data_word = 16'hffff;
    queue_item(it);
    it.func = FUNC_LEVEL;
    queue_item(it);
    it.data_word = 16'h0000;
    queue_item(it);
    for (int j = 0; j < SCAN_EVERY; j++) begin
      it = '0;
      it.func = FUNC_TICK;
      if (j % 2 == 1) begin
        // weekday seven, out-of-range time fields, key code three everywhere
        it.day_of_week = 3'd7; it.hour = 5'h1f; it.minute = 6'h3f; it.second = 6'h3f;
        it.key_down = KEY_ODD; it.key_up = KEY_ODD; it.key_arm = KEY_ODD;
      end
      if (j == SCAN_EVERY - 1) it.key_up = KEY_LONG;
      queue_item(it);
    end
    wait_drained();

    for (int p = 1; p <= PHASES; p++) begin
      // limit written only with nothing in flight
      secs = (p == 7) ? 14'($urandom_range(16383, 1)) : limit_plan[p-1];
      cfg_we   <= 1'b1;
      cfg_data <= secs;
      @(posedge clk_i);
      cfg_we <= 1'b0;
      mix            = (p - 1) % 4;
      send_idle_pct  = SEND_GAP_PCT[mix];
      recv_stall_pct = RECV_GAP_PCT[mix];
      phase_no       = p;
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        roll = $urandom_range(99);
        if (roll < 70) add_alarm_run();
        else if (roll < 88) add_key_run();
        else repeat ($urandom_range(6, 1)) queue_item(noise_item());
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (light_results_due.size() != 0)
      $error("%0d expected results never arrived", light_results_due.size());
    $display("Covered %0d items, %0d results checked, %0d alarm limit settings, four idling mixes.",
             items_queued, results_checked, PHASES);
    $display("Alarm starts %0d, timeouts %0d, ramp drives %0d, key actions %0d.",
             alarm_starts, alarm_timeouts, ramp_drives, key_actions);
    if (fail_count == 0 && light_results_due.size() == 0) begin
      $display("sunrise_alarm_light_controller verification clean");
    end else begin
      $display("sunrise_alarm_light_controller verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/salc_pkg.sv
rtl/core/salc_if.sv
rtl/core/salc_ctrl.sv
rtl/core/salc_dp.sv
rtl/core/sunrise_alarm_light_controller.sv
rtl/core/salc_chk.sv
dv/sunrise_alarm_light_controller_tb.sv
